// ===== hdl/quaternion_pose_and_inertia_transform_core_macros.svh =====
// assertion helpers shared by the rtl
`ifndef QUATERNION_POSE_AND_INERTIA_TRANSFORM_CORE_MACROS_SVH
`define QUATERNION_POSE_AND_INERTIA_TRANSFORM_CORE_MACROS_SVH

// clocked property, ignored while in reset
`define QPIT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked property that must also hold during reset
`define QPIT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/qpit_pkg.sv =====
package qpit_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W - FRAC_BITS;
    localparam int WORD_W    = 7 * DATA_W;
    localparam int ROW_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam logic signed [63:0] ONE = 64'sd1 <<< FRAC_BITS;

    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_XX = 3'd0,
        REG_XY = 3'd1,
        REG_XZ = 3'd2,
        REG_YY = 3'd3,
        REG_YZ = 3'd4,
        REG_ZZ = 3'd5
    } cfg_reg_t;

    typedef logic signed [DATA_W-1:0] fix_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    // fixed point product, floor of the exact product
    function automatic prod_t fmul(input fix_t a, input fix_t b);
        logic signed [63:0] full;
        logic signed [63:0] shifted;
        full    = 64'(a) * 64'(b);
        shifted = full >>> FRAC_BITS;
        return shifted[PROD_W-1:0];
    endfunction

    function automatic fix_t sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            return 32'sh80000000;
        else
            return v[DATA_W-1:0];
    endfunction

endpackage

// ===== hdl/quaternion_pose_and_inertia_transform_core.sv =====
// quaternion pose and inertia transform core
// input stream s_axis: one word per pose, quaternion r,i,j,k then position x,y,z,
// each signed q16.16. output stream m_axis: three words per pose, rows 0, 1, 2
// in order, each with the rotation row, the translation for that row and the
// world inverse inertia row R*I*R^T; tuser carries the row number, tlast marks row 2.
// the body inverse inertia is written over the cfg channel (index 0..5 = xx, xy,
// xz, yy, yz, zz); cfg_ready is always high, indexes above five are dropped.
// a row sequencer feeds one row a cycle, unless the output stalls, into a six stage
// multiply pipeline; a new pose can be taken while the sequencer holds the last row
// of the one before. the first row passes the sequencer, stages 1 to 5 and the
// output register, and rows 1 and 2 follow it in order.
// reset clears the inertia registers to zero and empties the pipeline.
// a stalled output freezes every stage together; nothing is dropped or repeated,
// and s_axis_tready falls until the output word is taken.
`include "quaternion_pose_and_inertia_transform_core_macros.svh"

module quaternion_pose_and_inertia_transform_core
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // quat_r, quat_i, quat_j, quat_k, pos_x, pos_y, pos_z
    input  logic [qpit_pkg::WORD_W-1:0]             s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // rot_col0, rot_col1, rot_col2, translation, world_col0, world_col1, world_col2
    output logic [qpit_pkg::WORD_W-1:0]             m_axis_tdata,
    // row_index
    output logic [qpit_pkg::ROW_W-1:0]              m_axis_tuser,
    output logic                                    m_axis_tlast,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [qpit_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [qpit_pkg::DATA_W-1:0]             cfg_data
);

    qpit_pkg::fix_t inertia_reg [6];

    logic en;
    logic accept;

    // row sequencer
    logic                          seq_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    seq_row_reg;
    qpit_pkg::fix_t                quat_reg [4];
    qpit_pkg::fix_t                pos_reg [3];

    // stage 1: quaternion products
    logic                          s1_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    s1_row_reg;
    qpit_pkg::fix_t                s1_pos_reg;
    qpit_pkg::prod_t               s1_p_reg [9];
    qpit_pkg::prod_t               s1_p_next [9];

    // stage 2: rotation matrix
    logic                          s2_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    s2_row_reg;
    qpit_pkg::fix_t                s2_pos_reg;
    qpit_pkg::fix_t                s2_r_reg [9];
    qpit_pkg::fix_t                s2_r_next [9];

    // stage 3: products of the rotation row with the body tensor
    logic                          s3_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    s3_row_reg;
    qpit_pkg::fix_t                s3_pos_reg;
    qpit_pkg::fix_t                s3_r_reg [9];
    qpit_pkg::fix_t                s3_rot_reg [3];
    qpit_pkg::prod_t               s3_p_reg [9];
    qpit_pkg::fix_t                s3_rot_next [3];
    qpit_pkg::prod_t               s3_p_next [9];
    qpit_pkg::fix_t                body [3][3];

    // stage 4: intermediate row
    logic                          s4_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    s4_row_reg;
    qpit_pkg::fix_t                s4_pos_reg;
    qpit_pkg::fix_t                s4_r_reg [9];
    qpit_pkg::fix_t                s4_rot_reg [3];
    qpit_pkg::fix_t                s4_t_reg [3];
    qpit_pkg::fix_t                s4_t_next [3];

    // stage 5: products with the transposed rotation
    logic                          s5_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    s5_row_reg;
    qpit_pkg::fix_t                s5_pos_reg;
    qpit_pkg::fix_t                s5_rot_reg [3];
    qpit_pkg::prod_t               s5_p_reg [9];
    qpit_pkg::prod_t               s5_p_next [9];

    // output register
    logic                          out_valid_reg;
    logic [qpit_pkg::ROW_W-1:0]    out_row_reg;
    qpit_pkg::fix_t                out_pos_reg;
    qpit_pkg::fix_t                out_rot_reg [3];
    qpit_pkg::fix_t                out_w_reg [3];
    qpit_pkg::fix_t                out_w_next [3];

    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en && (!seq_valid_reg || seq_row_reg == qpit_pkg::ROW_LAST);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                inertia_reg[i] <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                qpit_pkg::REG_XX: inertia_reg[0] <= cfg_data;
                qpit_pkg::REG_XY: inertia_reg[1] <= cfg_data;
                qpit_pkg::REG_XZ: inertia_reg[2] <= cfg_data;
                qpit_pkg::REG_YY: inertia_reg[3] <= cfg_data;
                qpit_pkg::REG_YZ: inertia_reg[4] <= cfg_data;
                qpit_pkg::REG_ZZ: inertia_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits and row numbers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_valid_reg <= 1'b0;
            seq_row_reg   <= qpit_pkg::ROW_FIRST;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            s1_row_reg    <= qpit_pkg::ROW_FIRST;
            s2_row_reg    <= qpit_pkg::ROW_FIRST;
            s3_row_reg    <= qpit_pkg::ROW_FIRST;
            s4_row_reg    <= qpit_pkg::ROW_FIRST;
            s5_row_reg    <= qpit_pkg::ROW_FIRST;
            out_row_reg   <= qpit_pkg::ROW_FIRST;
        end
        else if (en)
        begin
            if (accept)
            begin
                seq_valid_reg <= 1'b1;
                seq_row_reg   <= qpit_pkg::ROW_FIRST;
            end
            else if (seq_valid_reg)
            begin
                if (seq_row_reg == qpit_pkg::ROW_LAST)
                    seq_valid_reg <= 1'b0;
                else
                    seq_row_reg <= seq_row_reg + 2'd1;
            end
            s1_valid_reg  <= seq_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
            s1_row_reg    <= seq_row_reg;
            s2_row_reg    <= s1_row_reg;
            s3_row_reg    <= s2_row_reg;
            s4_row_reg    <= s3_row_reg;
            s5_row_reg    <= s4_row_reg;
            out_row_reg   <= s5_row_reg;
        end
    end

    // stage 1 products: jj kk ij kr ik jr ii jk ir
    always_comb
    begin
        s1_p_next[0] = qpit_pkg::fmul(quat_reg[2], quat_reg[2]);
        s1_p_next[1] = qpit_pkg::fmul(quat_reg[3], quat_reg[3]);
        s1_p_next[2] = qpit_pkg::fmul(quat_reg[1], quat_reg[2]);
        s1_p_next[3] = qpit_pkg::fmul(quat_reg[3], quat_reg[0]);
        s1_p_next[4] = qpit_pkg::fmul(quat_reg[1], quat_reg[3]);
        s1_p_next[5] = qpit_pkg::fmul(quat_reg[2], quat_reg[0]);
        s1_p_next[6] = qpit_pkg::fmul(quat_reg[1], quat_reg[1]);
        s1_p_next[7] = qpit_pkg::fmul(quat_reg[2], quat_reg[3]);
        s1_p_next[8] = qpit_pkg::fmul(quat_reg[1], quat_reg[0]);
    end

    always_comb
    begin
        logic signed [63:0] jj, kk, ij, kr, ik, jr, ii, jk, ir;
        jj = 64'(s1_p_reg[0]) * 64'sd2;
        kk = 64'(s1_p_reg[1]) * 64'sd2;
        ij = 64'(s1_p_reg[2]) * 64'sd2;
        kr = 64'(s1_p_reg[3]) * 64'sd2;
        ik = 64'(s1_p_reg[4]) * 64'sd2;
        jr = 64'(s1_p_reg[5]) * 64'sd2;
        ii = 64'(s1_p_reg[6]) * 64'sd2;
        jk = 64'(s1_p_reg[7]) * 64'sd2;
        ir = 64'(s1_p_reg[8]) * 64'sd2;
        s2_r_next[0] = qpit_pkg::sat32(qpit_pkg::ONE - (jj + kk));
        s2_r_next[1] = qpit_pkg::sat32(ij + kr);
        s2_r_next[2] = qpit_pkg::sat32(ik - jr);
        s2_r_next[3] = qpit_pkg::sat32(ij - kr);
        s2_r_next[4] = qpit_pkg::sat32(qpit_pkg::ONE - (ii + kk));
        s2_r_next[5] = qpit_pkg::sat32(jk + ir);
        s2_r_next[6] = qpit_pkg::sat32(ik + jr);
        s2_r_next[7] = qpit_pkg::sat32(jk - ir);
        s2_r_next[8] = qpit_pkg::sat32(qpit_pkg::ONE - (ii + jj));
    end

    always_comb
    begin
        body[0][0] = inertia_reg[0];
        body[0][1] = inertia_reg[1];
        body[0][2] = inertia_reg[2];
        body[1][0] = inertia_reg[1];
        body[1][1] = inertia_reg[3];
        body[1][2] = inertia_reg[4];
        body[2][0] = inertia_reg[2];
        body[2][1] = inertia_reg[4];
        body[2][2] = inertia_reg[5];
    end

    always_comb
    begin
        case (s2_row_reg)
            qpit_pkg::ROW_FIRST:
            begin
                s3_rot_next[0] = s2_r_reg[0];
                s3_rot_next[1] = s2_r_reg[1];
                s3_rot_next[2] = s2_r_reg[2];
            end
            qpit_pkg::ROW_MID:
            begin
                s3_rot_next[0] = s2_r_reg[3];
                s3_rot_next[1] = s2_r_reg[4];
                s3_rot_next[2] = s2_r_reg[5];
            end
            default:
            begin
                s3_rot_next[0] = s2_r_reg[6];
                s3_rot_next[1] = s2_r_reg[7];
                s3_rot_next[2] = s2_r_reg[8];
            end
        endcase
        // index c*3+m: column c, summed over m
        for (int c = 0; c < 3; c++)
            for (int m = 0; m < 3; m++)
                s3_p_next[c*3+m] = qpit_pkg::fmul(s3_rot_next[m], body[m][c]);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            s4_t_next[c] = qpit_pkg::sat32(64'(s3_p_reg[c*3]) + 64'(s3_p_reg[c*3+1])
                                           + 64'(s3_p_reg[c*3+2]));
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int m = 0; m < 3; m++)
                s5_p_next[c*3+m] = qpit_pkg::fmul(s4_t_reg[m], s4_r_reg[c*3+m]);
    end

    always_comb
    begin
        for (int c = 0; c < 3; c++)
            out_w_next[c] = qpit_pkg::sat32(64'(s5_p_reg[c*3]) + 64'(s5_p_reg[c*3+1])
                                            + 64'(s5_p_reg[c*3+2]));
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                for (int i = 0; i < 4; i++)
                    quat_reg[i] <= s_axis_tdata[i*qpit_pkg::DATA_W +: qpit_pkg::DATA_W];
                for (int i = 0; i < 3; i++)
                    pos_reg[i] <= s_axis_tdata[(i+4)*qpit_pkg::DATA_W +: qpit_pkg::DATA_W];
            end
            case (seq_row_reg)
                qpit_pkg::ROW_FIRST: s1_pos_reg <= pos_reg[0];
                qpit_pkg::ROW_MID:   s1_pos_reg <= pos_reg[1];
                default:             s1_pos_reg <= pos_reg[2];
            endcase
            s1_p_reg   <= s1_p_next;
            s2_pos_reg <= s1_pos_reg;
            s2_r_reg   <= s2_r_next;
            s3_pos_reg <= s2_pos_reg;
            s3_r_reg   <= s2_r_reg;
            s3_rot_reg <= s3_rot_next;
            s3_p_reg   <= s3_p_next;
            s4_pos_reg <= s3_pos_reg;
            s4_r_reg   <= s3_r_reg;
            s4_rot_reg <= s3_rot_reg;
            s4_t_reg   <= s4_t_next;
            s5_pos_reg <= s4_pos_reg;
            s5_rot_reg <= s4_rot_reg;
            s5_p_reg   <= s5_p_next;
            out_pos_reg <= s5_pos_reg;
            out_rot_reg <= s5_rot_reg;
            out_w_reg   <= out_w_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_row_reg;
    assign m_axis_tlast  = (out_row_reg == qpit_pkg::ROW_LAST);
    assign m_axis_tdata  = {out_w_reg[2], out_w_reg[1], out_w_reg[0], out_pos_reg,
                            out_rot_reg[2], out_rot_reg[1], out_rot_reg[0]};

    `QPIT_ASSERT(a_seq_row_range, seq_valid_reg |-> (seq_row_reg != 2'd3), "sequencer row out of range")
    `QPIT_ASSERT(a_accept_starts_row0, accept |=> (seq_valid_reg && seq_row_reg == qpit_pkg::ROW_FIRST), "accepted pose did not start at row 0")
    `QPIT_ASSERT(a_no_accept_mid_pose, (seq_valid_reg && seq_row_reg != qpit_pkg::ROW_LAST) |-> !s_axis_tready, "pose accepted while rows remain")
    `QPIT_ASSERT(a_row_order, (s1_valid_reg && en && s1_row_reg != qpit_pkg::ROW_LAST) |=> (s1_valid_reg && s1_row_reg == $past(s1_row_reg) + 2'd1), "rows of a pose not consecutive")

endmodule

// ===== verif/tb_quaternion_pose_and_inertia_transform_core.sv =====
module tb_quaternion_pose_and_inertia_transform_core;

    typedef struct packed {
        logic [1:0]  row;
        logic [31:0] rot0;
        logic [31:0] rot1;
        logic [31:0] rot2;
        logic [31:0] trans;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic        last;
    } row_word_t;

    typedef logic [qpit_pkg::CFG_IDX_W-1:0] cfg_idx_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    // quat_r, quat_i, quat_j, quat_k, pos_x, pos_y, pos_z
    logic [qpit_pkg::WORD_W-1:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    // rot_col0, rot_col1, rot_col2, translation, world_col0, world_col1, world_col2
    logic [qpit_pkg::WORD_W-1:0] m_axis_tdata;
    // row_index
    logic [qpit_pkg::ROW_W-1:0] m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    cfg_idx_t cfg_index;
    logic [qpit_pkg::DATA_W-1:0] cfg_data;

    quaternion_pose_and_inertia_transform_core dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    logic signed [31:0] inertia_regs [6];
    row_word_t expected_rows [$];
    int errors = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >>> qpit_pkg::FRAC_BITS);
    endfunction

    function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    task automatic predict_pose(input logic [qpit_pkg::WORD_W-1:0] pose);
        logic signed [63:0] r, i, j, k, acc, one;
        logic signed [63:0] rot [3][3];
        logic signed [63:0] body [3][3];
        logic signed [63:0] tmp [3][3];
        logic signed [63:0] world [3][3];
        row_word_t w;
        one = 64'sd1 <<< qpit_pkg::FRAC_BITS;
        r = 64'(signed'(pose[31:0]));
        i = 64'(signed'(pose[63:32]));
        j = 64'(signed'(pose[95:64]));
        k = 64'(signed'(pose[127:96]));
        rot[0][0] = clamp32(one - (2 * qmul(j, j) + 2 * qmul(k, k)));
        rot[0][1] = clamp32(2 * qmul(i, j) + 2 * qmul(k, r));
        rot[0][2] = clamp32(2 * qmul(i, k) - 2 * qmul(j, r));
        rot[1][0] = clamp32(2 * qmul(i, j) - 2 * qmul(k, r));
        rot[1][1] = clamp32(one - (2 * qmul(i, i) + 2 * qmul(k, k)));
        rot[1][2] = clamp32(2 * qmul(j, k) + 2 * qmul(i, r));
        rot[2][0] = clamp32(2 * qmul(i, k) + 2 * qmul(j, r));
        rot[2][1] = clamp32(2 * qmul(j, k) - 2 * qmul(i, r));
        rot[2][2] = clamp32(one - (2 * qmul(i, i) + 2 * qmul(j, j)));
        body[0][0] = inertia_regs[qpit_pkg::REG_XX];
        body[0][1] = inertia_regs[qpit_pkg::REG_XY];
        body[0][2] = inertia_regs[qpit_pkg::REG_XZ];
        body[1][0] = inertia_regs[qpit_pkg::REG_XY];
        body[1][1] = inertia_regs[qpit_pkg::REG_YY];
        body[1][2] = inertia_regs[qpit_pkg::REG_YZ];
        body[2][0] = inertia_regs[qpit_pkg::REG_XZ];
        body[2][1] = inertia_regs[qpit_pkg::REG_YZ];
        body[2][2] = inertia_regs[qpit_pkg::REG_ZZ];
        for (int n = 0; n < 3; n++)
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int m = 0; m < 3; m++)
                    acc += qmul(rot[n][m], body[m][c]);
                tmp[n][c] = clamp32(acc);
            end
        for (int n = 0; n < 3; n++)
            for (int c = 0; c < 3; c++)
            begin
                acc = 0;
                for (int m = 0; m < 3; m++)
                    acc += qmul(tmp[n][m], rot[c][m]);
                world[n][c] = clamp32(acc);
            end
        for (int n = 0; n < 3; n++)
        begin
            w.row = 2'(n);
            w.rot0 = rot[n][0][31:0];
            w.rot1 = rot[n][1][31:0];
            w.rot2 = rot[n][2][31:0];
            w.trans = pose[128 + 32*n +: 32];
            w.w0 = world[n][0][31:0];
            w.w1 = world[n][1][31:0];
            w.w2 = world[n][2][31:0];
            w.last = (n == 2);
            expected_rows.push_back(w);
        end
    endtask

    // output side: random stall and check
    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        row_word_t got, exp_w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = {m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                   m_axis_tdata[95:64], m_axis_tdata[127:96], m_axis_tdata[159:128],
                   m_axis_tdata[191:160], m_axis_tdata[223:192], m_axis_tlast};
            if (expected_rows.size() == 0)
            begin
                $display("%0t unexpected row word: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_w = expected_rows.pop_front();
                if (got !== exp_w)
                begin
                    $display("%0t row mismatch: expected %h, actual %h", $time, exp_w, got);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 5000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx < 6)
            inertia_regs[idx] = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // leaves tvalid high; a drain, or an idle gap in the next send, takes it down
    task automatic send_pose(input logic [qpit_pkg::WORD_W-1:0] pose, input bit use_model);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= pose;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (use_model)
            predict_pose(pose);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_fix();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(131072)) - 65536);
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(65536)) - 32768);
        endcase
    endfunction

    task automatic config_inertia(input int mode);
        for (int r = 0; r < 6; r++)
            case (mode)
                0: write_reg(cfg_idx_t'(r), 32'h7fffffff);
                1: write_reg(cfg_idx_t'(r), 32'h80000000);
                default: write_reg(cfg_idx_t'(r), rand_fix());
            endcase
    endtask

    localparam logic [31:0] ONE_FIX = 32'h0001_0000;
    localparam logic [31:0] HALF_FIX = 32'h0000_8000;
    localparam logic [31:0] MAXV = 32'h7fff_ffff;
    localparam logic [31:0] MINV = 32'h8000_0000;

    // identity pose right after reset: identity rows, zero translation, zero world tensor
    row_word_t ident_rows [3] = '{
        '{2'd0, ONE_FIX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{2'd1, 32'h0, ONE_FIX, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0},
        '{2'd2, 32'h0, 32'h0, ONE_FIX, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}
    };

    // r, i, j, k, x, y, z
    logic [31:0] pose_rows [12][7] = '{
        '{ONE_FIX, 0, 0, 0, 0, 0, 0},
        '{0, ONE_FIX, 0, 0, 32'h1234_5678, 32'hfedc_ba98, 32'h0000_0001},
        '{0, 0, ONE_FIX, 0, MAXV, MINV, 0},
        '{0, 0, 0, ONE_FIX, MINV, MAXV, 32'hffff_ffff},
        '{HALF_FIX, HALF_FIX, HALF_FIX, HALF_FIX, 1, 2, 3},
        '{32'hffff_8000, HALF_FIX, 32'hffff_8000, HALF_FIX, 0, 0, 0},
        '{32'h0002_0000, 0, 0, 0, 0, 0, 0},
        '{MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV},
        '{MINV, MINV, MINV, MINV, MINV, MINV, MINV},
        '{MAXV, MINV, MAXV, MINV, 0, 0, 0},
        '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0},
        '{0, 0, 0, 0, 32'haaaa_aaaa, 32'h5555_5555, 0}
    };

    initial
    begin
        logic [qpit_pkg::WORD_W-1:0] pose;
        logic [qpit_pkg::WORD_W-1:0] all_zero_word;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        all_zero_word = '0;
        for (int r = 0; r < 6; r++)
            inertia_regs[r] = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // after reset the world tensor is zero and identity gives identity rows
        for (int n = 0; n < 3; n++)
            expected_rows.push_back(ident_rows[n]);
        pose = '0;
        pose[31:0] = ONE_FIX;
        send_pose(pose, 1'b0);
        send_pose(all_zero_word, 1'b1);
        drain();
        // out-of-range indexes must leave the registers alone
        write_reg(3'd6, 32'hdead_beef);
        write_reg(3'd7, 32'hdead_beef);
        config_inertia(0);
        for (int t = 0; t < 12; t++)
        begin
            for (int f = 0; f < 7; f++)
                pose[32*f +: 32] = pose_rows[t][f];
            send_pose(pose, 1'b1);
        end
        drain();
        config_inertia(1);
        for (int t = 0; t < 6; t++)
        begin
            for (int f = 0; f < 7; f++)
                pose[32*f +: 32] = pose_rows[t][f];
            send_pose(pose, 1'b1);
        end

        for (int ph = 0; ph < 5; ph++)
        begin
            drain();
            config_inertia(2);
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                3: begin idle_pct = 15; stall_pct = 15; end
                default: begin idle_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < 20; n++)
            begin
                for (int f = 0; f < 7; f++)
                    pose[32*f +: 32] = rand_fix();
                send_pose(pose, 1'b1);
                if (n == 10)
                    drain();
            end
        end
        drain();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
